/* hw/rtl/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg
// shared constants, types and the byte-wide crc-32 update for the
// status frame checker
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned CountW    = 4;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CrcW      = 32;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [CrcW-1:0]   CrcPoly        = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]   CrcInit        = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0]  Magic0         = 8'h4F;
  localparam logic [DataW-1:0]  Magic1         = 8'h54;
  localparam logic [DataW-1:0]  Magic2         = 8'h51;
  localparam logic [DataW-1:0]  Magic3         = 8'h30;
  localparam logic [DataW-1:0]  FrameBytes     = 8'd12;
  localparam logic [CountW-1:0] FrameCount     = 4'd12;
  localparam logic [CountW-1:0] CountMax       = 4'd15;
  localparam logic [CountW-1:0] CrcSpan        = 4'd8;
  localparam logic [CountW-1:0] ChecksumOffset = 4'd8;
  localparam logic [DataW-1:0]  KindMax        = 8'd3;
  localparam logic [DataW-1:0]  VersionReset   = 8'd1;

  // byte offsets inside the frame
  localparam logic [CountW-1:0] OffMagic0   = 4'd0;
  localparam logic [CountW-1:0] OffMagic1   = 4'd1;
  localparam logic [CountW-1:0] OffMagic2   = 4'd2;
  localparam logic [CountW-1:0] OffMagic3   = 4'd3;
  localparam logic [CountW-1:0] OffVersion  = 4'd4;
  localparam logic [CountW-1:0] OffLength   = 4'd5;
  localparam logic [CountW-1:0] OffKind     = 4'd6;
  localparam logic [CountW-1:0] OffReserved = 4'd7;

  // register index of expected_version
  localparam logic RegVersion = 1'b0;

  typedef enum logic [StatusW-1:0] {
    StOk         = 3'd0,
    StMalformed  = 3'd1,
    StBadVersion = 3'd2,
    StBadKind    = 3'd3,
    StReserved   = 3'd4,
    StCrcError   = 3'd5
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [KindW-1:0] kind;
  } result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [CrcW-1:0] crc32_byte(input logic [CrcW-1:0]  crc,
                                                 input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-DataW){1'b0}}, b};
    for (int i = 0; i < DataW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hw/rtl/sfc_in_if.sv */
// ----------------------------------------------------------------------------
// sfc_in_if
// byte stream channel into the status frame checker
// ----------------------------------------------------------------------------
interface sfc_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfc_pkg::DataW-1:0] data_byte;
  logic                      last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

/* hw/rtl/sfc_out_if.sv */
// ----------------------------------------------------------------------------
// sfc_out_if
// frame status channel out of the status frame checker
// ----------------------------------------------------------------------------
interface sfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [sfc_pkg::StatusW-1:0] status;
  logic [sfc_pkg::KindW-1:0]   status_kind;

  modport source (output valid, output status, output status_kind, input ready);
  modport sink   (input valid, input status, input status_kind, output ready);
endinterface

/* hw/rtl/sfc_frame_core.sv */
// ----------------------------------------------------------------------------
// sfc_frame_core
// per-frame state: byte position, running crc, received crc and fault
// flags; works out the frame status on the last byte
// ----------------------------------------------------------------------------
module sfc_frame_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [sfc_pkg::DataW-1:0]   data_i,
  input  logic                        last_i,
  input  logic [sfc_pkg::DataW-1:0]   version_i,
  output sfc_pkg::result_t            result_o
);

  logic [sfc_pkg::CountW-1:0] count_q, count_d;
  logic [sfc_pkg::CrcW-1:0]   crc_q, crc_d;
  logic [sfc_pkg::CrcW-1:0]   rx_crc_q, rx_crc_d;
  logic                       malformed_q, malformed_d;
  logic                       version_bad_q, version_bad_d;
  logic                       kind_bad_q, kind_bad_d;
  logic                       reserved_bad_q, reserved_bad_d;
  logic [sfc_pkg::KindW-1:0]  kind_q, kind_d;

  always_comb begin
    count_d        = count_q;
    crc_d          = crc_q;
    rx_crc_d       = rx_crc_q;
    malformed_d    = malformed_q;
    version_bad_d  = version_bad_q;
    kind_bad_d     = kind_bad_q;
    reserved_bad_d = reserved_bad_q;
    kind_d         = kind_q;

    unique case (count_q)
      sfc_pkg::OffMagic0:   if (data_i != sfc_pkg::Magic0) malformed_d = 1'b1;
      sfc_pkg::OffMagic1:   if (data_i != sfc_pkg::Magic1) malformed_d = 1'b1;
      sfc_pkg::OffMagic2:   if (data_i != sfc_pkg::Magic2) malformed_d = 1'b1;
      sfc_pkg::OffMagic3:   if (data_i != sfc_pkg::Magic3) malformed_d = 1'b1;
      sfc_pkg::OffVersion:  if (data_i != version_i) version_bad_d = 1'b1;
      sfc_pkg::OffLength:   if (data_i != sfc_pkg::FrameBytes) malformed_d = 1'b1;
      sfc_pkg::OffKind: begin
        if (data_i > sfc_pkg::KindMax) kind_bad_d = 1'b1;
        kind_d = data_i[sfc_pkg::KindW-1:0];
      end
      sfc_pkg::OffReserved: if (data_i != '0) reserved_bad_d = 1'b1;
      default: ;
    endcase

    // checksum bytes arrive little endian at offsets 8..11
    if (count_q[3:2] == sfc_pkg::ChecksumOffset[3:2]) begin
      unique case (count_q[1:0])
        2'd0:    rx_crc_d[7:0]   = rx_crc_q[7:0]   | data_i;
        2'd1:    rx_crc_d[15:8]  = rx_crc_q[15:8]  | data_i;
        2'd2:    rx_crc_d[23:16] = rx_crc_q[23:16] | data_i;
        default: rx_crc_d[31:24] = rx_crc_q[31:24] | data_i;
      endcase
    end

    if (count_q < sfc_pkg::CrcSpan) begin
      crc_d = sfc_pkg::crc32_byte(crc_q, data_i);
    end

    if (count_q != sfc_pkg::CountMax) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    result_o.kind = '0;
    priority if (count_d != sfc_pkg::FrameCount || malformed_d) begin
      result_o.status = sfc_pkg::StMalformed;
    end else if (version_bad_d) begin
      result_o.status = sfc_pkg::StBadVersion;
    end else if (kind_bad_d) begin
      result_o.status = sfc_pkg::StBadKind;
    end else if (reserved_bad_d) begin
      result_o.status = sfc_pkg::StReserved;
    end else if ((crc_d ^ sfc_pkg::CrcInit) != rx_crc_d) begin
      result_o.status = sfc_pkg::StCrcError;
    end else begin
      result_o.status = sfc_pkg::StOk;
      result_o.kind   = kind_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      crc_q          <= sfc_pkg::CrcInit;
      rx_crc_q       <= '0;
      malformed_q    <= 1'b0;
      version_bad_q  <= 1'b0;
      kind_bad_q     <= 1'b0;
      reserved_bad_q <= 1'b0;
      kind_q         <= '0;
    end else if (step_i) begin
      if (last_i) begin
        // frame done, start clean
        count_q        <= '0;
        crc_q          <= sfc_pkg::CrcInit;
        rx_crc_q       <= '0;
        malformed_q    <= 1'b0;
        version_bad_q  <= 1'b0;
        kind_bad_q     <= 1'b0;
        reserved_bad_q <= 1'b0;
        kind_q         <= '0;
      end else begin
        count_q        <= count_d;
        crc_q          <= crc_d;
        rx_crc_q       <= rx_crc_d;
        malformed_q    <= malformed_d;
        version_bad_q  <= version_bad_d;
        kind_bad_q     <= kind_bad_d;
        reserved_bad_q <= reserved_bad_d;
        kind_q         <= kind_d;
      end
    end
  end

endmodule

/* hw/rtl/status_frame_checker.sv */
// a frame's status is registered as its last byte leaves the input register
// throughput: one byte per cycle, unless a last byte waits for a free output;
//   crc-32 byte update and field checks sit between input and result registers
// reset clears the frame state and the output valid, and sets expected_version to 1
// ----------------------------------------------------------------------------
// status_frame_checker
// checks 12-byte status frames: magic, version, length, kind, reserved byte
// and a crc-32 over the first eight bytes; one status per frame
// ----------------------------------------------------------------------------
module status_frame_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sfc_in_if.sink                         in_i,
  sfc_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [sfc_pkg::ApbDataW-1:0]   pwdata,
  output logic [sfc_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  logic [sfc_pkg::DataW-1:0]   version_q;
  logic                        cfg_we;

  logic                        in_valid_q;
  logic [sfc_pkg::DataW-1:0]   in_data_q;
  logic                        in_last_q;
  logic                        step;
  logic                        out_free;

  logic                        out_valid_q;
  sfc_pkg::result_t            res_q;
  sfc_pkg::result_t            res_d;

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[2] == sfc_pkg::RegVersion);
  assign prdata = (paddr[2] == sfc_pkg::RegVersion)
                  ? {{(sfc_pkg::ApbDataW-sfc_pkg::DataW){1'b0}}, version_q}
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= sfc_pkg::VersionReset;
    end else if (cfg_we) begin
      version_q <= pwdata[sfc_pkg::DataW-1:0];
    end
  end

  // input register; a non-last byte never waits on the output side
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_data_q <= in_i.data_byte;
      in_last_q <= in_i.last;
    end
  end

  sfc_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .data_i    (in_data_q),
    .last_i    (in_last_q),
    .version_i (version_q),
    .result_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = res_q.status;
  assign out_o.status_kind = res_q.kind;

endmodule

/* test/status_frame_checker_tb.sv */
// ----------------------------------------------------------------------------
// status_frame_checker_tb
// drives byte streams of status frames into the checker under random gaps and
// stalls, predicts one status per frame and compares every status in order;
// also exercises the version register through the apb port
// ----------------------------------------------------------------------------
module status_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfc_pkg::*;

  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;
  localparam int RandomBytes = 280;
  localparam int TimeLimitNs = 1_000_000;

  logic clk = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  sfc_in_if  in_ch ();
  sfc_out_if out_ch ();

  status_frame_checker i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted frame state
  logic [DataW-1:0]  cfg_version;
  logic [CountW-1:0] fr_count;
  logic [CrcW-1:0]   fr_crc;
  logic [CrcW-1:0]   fr_rx_crc;
  logic              fr_malformed;
  logic              fr_version_bad;
  logic              fr_kind_bad;
  logic              fr_reserved_bad;
  logic [KindW-1:0]  fr_kind;

  result_t status_due [$];
  logic [DataW-1:0] frame_buf [$];

  int  err_count    = 0;
  int  bytes_sent   = 0;
  int  frames_sent  = 0;
  int  status_count = 0;
  int  status_seen [6];
  bit  gaps_on      = 1'b1;
  bit  hold_req     = 1'b0;

  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0]  crc,
                                               input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    logic            fb;
    c = crc;
    for (int i = 0; i < DataW; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CrcPoly;
    end
    return c;
  endfunction

  function automatic void clear_frame();
    fr_count        = '0;
    fr_crc          = CrcInit;
    fr_rx_crc       = '0;
    fr_malformed    = 1'b0;
    fr_version_bad  = 1'b0;
    fr_kind_bad     = 1'b0;
    fr_reserved_bad = 1'b0;
    fr_kind         = '0;
  endfunction

  task automatic note_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  // fold one accepted byte into the frame state, queue a status on the last byte
  task automatic absorb_byte(input logic [DataW-1:0] b, input logic is_last);
    logic [CountW-1:0] pos;
    result_t           r;
    pos = fr_count;
    case (pos)
      OffMagic0:   if (b != Magic0) fr_malformed = 1'b1;
      OffMagic1:   if (b != Magic1) fr_malformed = 1'b1;
      OffMagic2:   if (b != Magic2) fr_malformed = 1'b1;
      OffMagic3:   if (b != Magic3) fr_malformed = 1'b1;
      OffVersion:  if (b != cfg_version) fr_version_bad = 1'b1;
      OffLength:   if (b != FrameBytes) fr_malformed = 1'b1;
      OffKind: begin
        if (b > KindMax) fr_kind_bad = 1'b1;
        fr_kind = b[KindW-1:0];
      end
      OffReserved: if (b != '0) fr_reserved_bad = 1'b1;
      ChecksumOffset, ChecksumOffset + 4'd1, ChecksumOffset + 4'd2, ChecksumOffset + 4'd3:
        fr_rx_crc = fr_rx_crc | ({24'b0, b} << (8 * (pos - ChecksumOffset)));
      default: ;
    endcase
    if (pos < CrcSpan) fr_crc = crc_step(fr_crc, b);
    if (fr_count < CountMax) fr_count = fr_count + 4'd1;
    if (is_last) begin
      r.kind = '0;
      if (fr_count != FrameCount || fr_malformed) r.status = StMalformed;
      else if (fr_version_bad) r.status = StBadVersion;
      else if (fr_kind_bad) r.status = StBadKind;
      else if (fr_reserved_bad) r.status = StReserved;
      else if ((fr_crc ^ CrcInit) != fr_rx_crc) r.status = StCrcError;
      else begin
        r.status = StOk;
        r.kind   = fr_kind;
      end
      status_due.push_back(r);
      clear_frame();
    end
  endtask

  always @(posedge clk) begin : score
    result_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data_byte, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        if (status_due.size() == 0) begin
          note_error($sformatf("status %0d kind %0d with no frame pending",
                               out_ch.status, out_ch.status_kind));
        end else begin
          want = status_due.pop_front();
          status_count++;
          status_seen[int'(want.status)]++;
          if (out_ch.status !== want.status || out_ch.status_kind !== want.kind) begin
            note_error($sformatf("frame status mismatch: exp %0d/%0d got %0d/%0d",
                                 want.status, want.kind, out_ch.status, out_ch.status_kind));
          end
        end
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // status sink: random stalls, or a long hold-off on request
  initial begin : sink
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [DataW-1:0] b, input logic is_last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    if (is_last) frames_sent++;
    @(negedge clk);
  endtask

  task automatic send_span(input int lo, input int hi, input bit mark_last);
    for (int i = lo; i <= hi; i++) send_byte(frame_buf[i], mark_last && i == hi);
  endtask

  task automatic send_frame();
    send_span(0, frame_buf.size() - 1, 1'b1);
  endtask

  task automatic build_frame(input logic [DataW-1:0] ver, input logic [DataW-1:0] kind_b,
                             input logic [DataW-1:0] rsvd);
    logic [CrcW-1:0] c;
    frame_buf = {Magic0, Magic1, Magic2, Magic3, ver, FrameBytes, kind_b, rsvd};
    c = CrcInit;
    foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
    c = c ^ CrcInit;
    for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
  endtask

  // wait for all statuses, then let the pipeline run dry
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // an idle phase with psel low first so back-to-back transfers never collide
  task automatic write_reg(input int idx, input logic [ApbDataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == int'(RegVersion)) cfg_version = value[DataW-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_version_back();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(int'(RegVersion) * 4);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== ApbDataW'(cfg_version)) begin
      note_error($sformatf("version readback: exp %0h got %0h", cfg_version, prdata));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_register_access();
    read_version_back();
    // writes to an unmapped index must leave the version alone
    write_reg(1, $urandom);
    read_version_back();
    write_reg(int'(RegVersion), 32'h0);
    read_version_back();
    write_reg(int'(RegVersion), 32'hFF);
    read_version_back();
    write_reg(int'(RegVersion), {24'hFF_FFFF, VersionReset});
    read_version_back();
  endtask

  task automatic test_directed_frames();
    for (int k = 0; k <= int'(KindMax); k++) begin
      build_frame(cfg_version, 8'(k), 8'h00);
      send_frame();
    end
    for (int p = 0; p < 4; p++) begin
      build_frame(cfg_version, 8'd1, 8'h00);
      frame_buf[p] = ~frame_buf[p];
      send_frame();
    end
    build_frame(cfg_version + 8'd1, 8'd2, 8'h00);
    send_frame();
    build_frame(cfg_version, 8'd0, 8'h00);
    frame_buf[OffLength] = 8'd11;
    send_frame();
    // kind out of range, alone and masking a reserved fault
    build_frame(cfg_version, 8'd4, 8'h00);
    send_frame();
    build_frame(cfg_version, 8'hFF, 8'h01);
    send_frame();
    build_frame(cfg_version, 8'd2, 8'h80);
    send_frame();
    build_frame(cfg_version, 8'd1, 8'hFF);
    frame_buf[11] ^= 8'h01;
    send_frame();
    build_frame(cfg_version, 8'd3, 8'h00);
    frame_buf[11] ^= 8'h80;
    send_frame();
    build_frame(cfg_version, 8'd0, 8'h00);
    frame_buf[8] ^= 8'h01;
    send_frame();
    build_frame(cfg_version + 8'd1, 8'd0, 8'h00);
    frame_buf[OffLength] = 8'd13;
    send_frame();
    // wrong frame lengths, including one long enough to saturate the count
    frame_buf = {Magic0};
    send_frame();
    build_frame(cfg_version, 8'd2, 8'h00);
    void'(frame_buf.pop_back());
    send_frame();
    build_frame(cfg_version, 8'd2, 8'h00);
    frame_buf.push_back(8'h00);
    send_frame();
    build_frame(cfg_version, 8'd3, 8'h00);
    repeat (8) frame_buf.push_back(8'($urandom));
    send_frame();
    build_frame(cfg_version, 8'd3, 8'h00);
    send_frame();
    settle();
  endtask

  task automatic test_version_register();
    write_reg(int'(RegVersion), 32'h00);
    build_frame(8'h00, 8'd1, 8'h00);
    send_frame();
    build_frame(8'h01, 8'd1, 8'h00);
    send_frame();
    settle();
    write_reg(int'(RegVersion), 32'hFF);
    build_frame(8'hFF, 8'd2, 8'h00);
    send_frame();
    build_frame(8'hFE, 8'd2, 8'h00);
    send_frame();
    // change before the version byte arrives: the new value applies
    build_frame(8'h5A, 8'd3, 8'h00);
    send_span(0, int'(OffVersion) - 1, 1'b0);
    settle();
    write_reg(int'(RegVersion), 32'h5A);
    send_span(int'(OffVersion), frame_buf.size() - 1, 1'b1);
    // change after the version byte: the old value was already used
    build_frame(8'h5A, 8'd0, 8'h00);
    send_span(0, int'(OffVersion), 1'b0);
    settle();
    write_reg(int'(RegVersion), 32'h33);
    send_span(int'(OffVersion) + 1, frame_buf.size() - 1, 1'b1);
    settle();
    read_version_back();
  endtask

  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      build_frame(cfg_version, 8'($urandom_range(0, 3)), 8'h00);
      send_frame();
    end
    settle();
    gaps_on = 1'b1;
  endtask

  task automatic send_random_frame();
    int r;
    int n;
    logic [DataW-1:0] ver;
    logic [DataW-1:0] kind_b;
    logic [DataW-1:0] rsvd;
    r      = $urandom_range(0, 99);
    ver    = ($urandom_range(0, 9) != 0) ? cfg_version : 8'($urandom);
    kind_b = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    rsvd   = ($urandom_range(0, 19) != 0) ? 8'h00 : 8'($urandom);
    if (r < 85) begin
      build_frame(ver, kind_b, rsvd);
      if (r < 65) begin
        if ($urandom_range(0, 9) == 0) frame_buf[$urandom_range(0, 11)] ^= 8'h01 << $urandom_range(0, 7);
      end else begin
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1) != 0) repeat (n) void'(frame_buf.pop_back());
        else repeat (n) frame_buf.push_back(8'($urandom));
      end
    end else begin
      frame_buf.delete();
      n = $urandom_range(1, 16);
      repeat (n) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 1) != 0) frame_buf[0] = Magic0;
    end
    send_frame();
  endtask

  task automatic test_random_frames();
    logic [DataW-1:0] phase_ver [4];
    int budget;
    phase_ver[0] = 8'($urandom);
    phase_ver[1] = 8'h00;
    phase_ver[2] = 8'hFF;
    phase_ver[3] = 8'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(int'(RegVersion), 32'(phase_ver[ph]));
      read_version_back();
      // one phase runs back to back with no gaps on either side
      gaps_on = (ph != 2);
      budget  = bytes_sent + RandomBytes / 4;
      while (bytes_sent < budget) send_random_frame();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last      = 1'b0;
    out_ch.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    cfg_version     = VersionReset;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_frame();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_directed_frames();
    test_version_register();
    test_backpressure();
    test_random_frames();

    settle();
    repeat (DrainCycles * 4) @(negedge clk);
    $display("run covered %0d bytes in %0d frames, %0d statuses compared, %0d errors",
             bytes_sent, frames_sent, status_count, err_count);
    $display("status mix: ok %0d malformed %0d version %0d kind %0d reserved %0d crc %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (err_count == 0 && status_due.size() == 0) begin
      $display("status_frame_checker_tb: clean");
    end else begin
      $display("status_frame_checker_tb: errors");
    end
    $finish;
  end

  initial begin
    #(TimeLimitNs);
    $display("status_frame_checker_tb: errors");
    $finish;
  end

endmodule

/* status_frame_checker.f */
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_in_if.sv
hw/rtl/sfc_out_if.sv
hw/rtl/sfc_frame_core.sv
hw/rtl/status_frame_checker.sv
test/status_frame_checker_tb.sv
